/* src/hsl2rgb_pkg.sv */
// shared constants and types for the hsl to rgb converter
`timescale 1ns / 1ps

package hsl2rgb_pkg;

    // hue circle is 5760 units of 1/16 degree, split as 45 << 7
    localparam int REGION_UNITS = 1920;
    localparam int H_LOW_W      = 7;
    localparam int MOD_DIV      = 45;
    localparam int REM_W        = 6;

    // reduced hue magnitude and primary weights, up to one region plus a circle
    localparam int MAG_W = 13;
    // divisor is twice the larger weight
    localparam int DEN_W = MAG_W + 1;

    typedef logic [MAG_W-1:0] mag_t;
    typedef logic [1:0]       rgn_t;

    // which primaries share the hue region: rising one first
    localparam rgn_t RGN_RB = 2'd0;
    localparam rgn_t RGN_GR = 2'd1;
    localparam rgn_t RGN_BG = 2'd2;

    localparam mag_t REGION_1 = MAG_W'(REGION_UNITS);
    localparam mag_t REGION_2 = MAG_W'(2 * REGION_UNITS);
    localparam mag_t REGION_3 = MAG_W'(3 * REGION_UNITS);

endpackage

/* src/hsl2rgb_div.sv */
// pipelined restoring divider, one quotient bit per stage, two lanes on one divisor
`timescale 1ns / 1ps

module hsl2rgb_div #(
    parameter int DEN_W = 14,
    parameter int QUO_W = 13,
    parameter int TAG_W = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [DEN_W+QUO_W-1:0] num_a,
    input  logic [DEN_W+QUO_W-1:0] num_b,
    input  logic [DEN_W-1:0]       den,
    input  logic [TAG_W-1:0]       tag,
    output logic                   out_valid,
    output logic [QUO_W-1:0]       quo_a,
    output logic [QUO_W-1:0]       quo_b,
    output logic [TAG_W-1:0]       tag_out
);

    localparam int STEP_W = DEN_W + QUO_W;

    logic                vld_reg  [QUO_W];
    logic [DEN_W-1:0]    rem_a_reg[QUO_W];
    logic [QUO_W-1:0]    nq_a_reg [QUO_W];
    logic [DEN_W-1:0]    rem_b_reg[QUO_W];
    logic [QUO_W-1:0]    nq_b_reg [QUO_W];
    logic [DEN_W-1:0]    den_reg  [QUO_W];
    logic [TAG_W-1:0]    tag_reg  [QUO_W];

    function automatic logic [STEP_W-1:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic [QUO_W-1:0] nq,
        input logic [DEN_W-1:0] d
    );
        logic [DEN_W:0] t;
        logic [DEN_W:0] diff;
        logic           take;
        t    = {rem, nq[QUO_W-1]};
        diff = t - {1'b0, d};
        take = (t >= {1'b0, d});
        return {(take ? diff[DEN_W-1:0] : t[DEN_W-1:0]), nq[QUO_W-2:0], take};
    endfunction

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        logic                vld_in;
        logic [DEN_W-1:0]    rem_a_in;
        logic [QUO_W-1:0]    nq_a_in;
        logic [DEN_W-1:0]    rem_b_in;
        logic [QUO_W-1:0]    nq_b_in;
        logic [DEN_W-1:0]    den_in;
        logic [TAG_W-1:0]    tag_in;
        logic [STEP_W-1:0]   step_a_next;
        logic [STEP_W-1:0]   step_b_next;

        if (i == 0)
        begin : g_first
            assign vld_in   = in_valid;
            assign rem_a_in = num_a[STEP_W-1:QUO_W];
            assign nq_a_in  = num_a[QUO_W-1:0];
            assign rem_b_in = num_b[STEP_W-1:QUO_W];
            assign nq_b_in  = num_b[QUO_W-1:0];
            assign den_in   = den;
            assign tag_in   = tag;
        end
        else
        begin : g_rest
            assign vld_in   = vld_reg[i-1];
            assign rem_a_in = rem_a_reg[i-1];
            assign nq_a_in  = nq_a_reg[i-1];
            assign rem_b_in = rem_b_reg[i-1];
            assign nq_b_in  = nq_b_reg[i-1];
            assign den_in   = den_reg[i-1];
            assign tag_in   = tag_reg[i-1];
        end

        assign step_a_next = div_step(rem_a_in, nq_a_in, den_in);
        assign step_b_next = div_step(rem_b_in, nq_b_in, den_in);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_a_reg[i] <= step_a_next[STEP_W-1:QUO_W];
            nq_a_reg[i]  <= step_a_next[QUO_W-1:0];
            rem_b_reg[i] <= step_b_next[STEP_W-1:QUO_W];
            nq_b_reg[i]  <= step_b_next[QUO_W-1:0];
            den_reg[i]   <= den_in;
            tag_reg[i]   <= tag_in;
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign quo_a     = nq_a_reg[QUO_W-1];
    assign quo_b     = nq_b_reg[QUO_W-1];
    assign tag_out   = tag_reg[QUO_W-1];

endmodule

/* src/hsl_to_rgb_color_convert.sv */
// hsl to rgb color converter, fixed point, fully pipelined
// done pulses once a request has passed stages 1 to 5, the divider and done_reg
// throughput: one request per cycle, busy stays low; depth is set by the divider,
// one quotient bit per stage for FRAC_BITS+1 stages
// reset: asynchronous, clears all valid bits, so no stale result is reported
`timescale 1ns / 1ps

module hsl_to_rgb_color_convert #(
    parameter int FRAC_BITS = 12,
    parameter int HUE_BITS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [HUE_BITS-1:0] hue,
    input  logic [FRAC_BITS:0]         saturation,
    input  logic [FRAC_BITS:0]         lightness,
    output logic                       busy,
    output logic                       done,
    output logic [FRAC_BITS:0]         red,
    output logic [FRAC_BITS:0]         green,
    output logic [FRAC_BITS:0]         blue
);

    import hsl2rgb_pkg::*;

    localparam int QW    = FRAC_BITS + 1;
    localparam int XW    = HUE_BITS - H_LOW_W;
    localparam int RSH   = XW + 6;
    localparam int KW    = XW + 2;
    localparam int PW    = XW + KW;
    localparam int QHW   = PW - RSH;
    localparam int DW3   = XW + REM_W;
    localparam int LW    = FRAC_BITS + 4;
    localparam int NW    = DEN_W + QW;
    localparam int TAG_W = 2 + 1 + LW;
    localparam int LAT   = FRAC_BITS + 7;

    localparam longint unsigned RECIP = ((64'd1 << RSH) + MOD_DIV - 1) / MOD_DIV;
    localparam logic [KW-1:0]   RECIP_K = KW'(RECIP);
    localparam logic [LW-1:0]   ONE_L   = LW'(1) << FRAC_BITS;
    localparam logic [QW-1:0]   ONE_Q   = QW'(1) << FRAC_BITS;

    // stage 1: hue magnitude
    logic                s1_vld_reg;
    logic                s1_neg_reg;
    logic [HUE_BITS-1:0] s1_mag_reg;
    logic [QW-1:0]       s1_sat_reg;
    logic [QW-1:0]       s1_lit_reg;
    logic [HUE_BITS-1:0] hue_abs;

    // stage 2: quotient by 45 through reciprocal
    logic                s2_vld_reg;
    logic                s2_neg_reg;
    logic [QHW-1:0]      s2_q_reg;
    logic [XW-1:0]       s2_x_reg;
    logic [H_LOW_W-1:0]  s2_low_reg;
    logic [QW-1:0]       s2_sat_reg;
    logic [QW-1:0]       s2_lit_reg;
    logic [PW-1:0]       recip_prod;

    // stage 3: reduced hue
    logic                s3_vld_reg;
    logic                s3_neg_reg;
    mag_t                s3_mag_reg;
    logic [QW-1:0]       s3_sat_reg;
    logic [QW-1:0]       s3_lit_reg;
    logic [DW3-1:0]      rem_diff;

    // stage 4: region weights and lightness term
    logic                s4_vld_reg;
    mag_t                s4_a_reg;
    mag_t                s4_b_reg;
    mag_t                s4_m_reg;
    logic                s4_aneg_reg;
    rgn_t                s4_rgn_reg;
    logic [QW-1:0]       s4_sat_reg;
    logic [LW-1:0]       s4_light_reg;
    mag_t                a_next;
    mag_t                b_next;
    mag_t                m_next;
    rgn_t                rgn_next;
    logic [LW-1:0]       light_next;

    // stage 5: rounded dividends
    logic                s5_vld_reg;
    logic [NW-1:0]       s5_num_a_reg;
    logic [NW-1:0]       s5_num_b_reg;
    logic [DEN_W-1:0]    s5_den_reg;
    logic [TAG_W-1:0]    s5_tag_reg;
    logic [NW-1:0]       prod_a;
    logic [NW-1:0]       prod_b;

    // divider and output
    logic                dv_vld;
    logic [QW-1:0]       dv_qa;
    logic [QW-1:0]       dv_qb;
    logic [TAG_W-1:0]    dv_tag;
    rgn_t                fin_rgn;
    logic                fin_aneg;
    logic [LW-1:0]       fin_light;
    logic [LW-1:0]       sum_a;
    logic [LW-1:0]       sum_b;
    logic [QW-1:0]       ch_a;
    logic [QW-1:0]       ch_b;
    logic [QW-1:0]       ch_z;
    logic                done_reg;
    logic [QW-1:0]       red_reg;
    logic [QW-1:0]       green_reg;
    logic [QW-1:0]       blue_reg;
    logic [QW-1:0]       red_next;
    logic [QW-1:0]       green_next;
    logic [QW-1:0]       blue_next;

    function automatic logic [QW-1:0] clamp_unit(input logic [LW-1:0] v);
        if (v[LW-1])
            return '0;
        else if (v > ONE_L)
            return ONE_Q;
        else
            return v[QW-1:0];
    endfunction

    assign busy = 1'b0;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            done_reg   <= dv_vld;
        end
    end

    assign hue_abs = hue[HUE_BITS-1] ? (~$unsigned(hue) + HUE_BITS'(1)) : $unsigned(hue);

    assign recip_prod = PW'(s1_mag_reg[HUE_BITS-1:H_LOW_W]) * PW'(RECIP_K);

    assign rem_diff = DW3'(s2_x_reg) - DW3'(s2_q_reg) * DW3'(MOD_DIV);

    always_comb
    begin
        if (s3_neg_reg)
        begin
            a_next   = s3_mag_reg;
            b_next   = REGION_1 + s3_mag_reg;
            rgn_next = RGN_RB;
        end
        else if (s3_mag_reg <= REGION_1)
        begin
            a_next   = s3_mag_reg;
            b_next   = REGION_1 - s3_mag_reg;
            rgn_next = RGN_RB;
        end
        else if (s3_mag_reg <= REGION_2)
        begin
            a_next   = s3_mag_reg - REGION_1;
            b_next   = REGION_2 - s3_mag_reg;
            rgn_next = RGN_GR;
        end
        else
        begin
            a_next   = s3_mag_reg - REGION_2;
            b_next   = REGION_3 - s3_mag_reg;
            rgn_next = RGN_BG;
        end
        m_next = (!s3_neg_reg && (a_next > b_next)) ? a_next : b_next;
        light_next = (s3_sat_reg != '0) ? ({2'b00, s3_lit_reg, 1'b0} - ONE_L)
                                        : {3'b000, s3_lit_reg};
    end

    assign prod_a = NW'(s4_a_reg) * NW'(s4_sat_reg);
    assign prod_b = NW'(s4_b_reg) * NW'(s4_sat_reg);

    always_ff @(posedge clk)
    begin
        s1_neg_reg   <= hue[HUE_BITS-1];
        s1_mag_reg   <= hue_abs;
        s1_sat_reg   <= saturation;
        s1_lit_reg   <= lightness;

        s2_neg_reg   <= s1_neg_reg;
        s2_q_reg     <= recip_prod[PW-1:RSH];
        s2_x_reg     <= s1_mag_reg[HUE_BITS-1:H_LOW_W];
        s2_low_reg   <= s1_mag_reg[H_LOW_W-1:0];
        s2_sat_reg   <= s1_sat_reg;
        s2_lit_reg   <= s1_lit_reg;

        s3_neg_reg   <= s2_neg_reg;
        s3_mag_reg   <= {rem_diff[REM_W-1:0], s2_low_reg};
        s3_sat_reg   <= s2_sat_reg;
        s3_lit_reg   <= s2_lit_reg;

        s4_a_reg     <= a_next;
        s4_b_reg     <= b_next;
        s4_m_reg     <= m_next;
        s4_aneg_reg  <= s3_neg_reg;
        s4_rgn_reg   <= rgn_next;
        s4_sat_reg   <= s3_sat_reg;
        s4_light_reg <= light_next;

        s5_num_a_reg <= (prod_a << 1) + NW'(s4_m_reg);
        s5_num_b_reg <= (prod_b << 1) + NW'(s4_m_reg);
        s5_den_reg   <= {s4_m_reg, 1'b0};
        s5_tag_reg   <= {s4_rgn_reg, s4_aneg_reg, s4_light_reg};
    end

    hsl2rgb_div #(
        .DEN_W (DEN_W),
        .QUO_W (QW),
        .TAG_W (TAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_vld_reg),
        .num_a     (s5_num_a_reg),
        .num_b     (s5_num_b_reg),
        .den       (s5_den_reg),
        .tag       (s5_tag_reg),
        .out_valid (dv_vld),
        .quo_a     (dv_qa),
        .quo_b     (dv_qb),
        .tag_out   (dv_tag)
    );

    assign fin_rgn   = dv_tag[TAG_W-1:TAG_W-2];
    assign fin_aneg  = dv_tag[LW];
    assign fin_light = dv_tag[LW-1:0];

    assign sum_a = (fin_aneg ? (LW'(0) - LW'(dv_qa)) : LW'(dv_qa)) + fin_light;
    assign sum_b = LW'(dv_qb) + fin_light;
    assign ch_a  = clamp_unit(sum_a);
    assign ch_b  = clamp_unit(sum_b);
    assign ch_z  = clamp_unit(fin_light);

    always_comb
    begin
        case (fin_rgn)
            RGN_RB:
            begin
                red_next   = ch_a;
                green_next = ch_z;
                blue_next  = ch_b;
            end
            RGN_GR:
            begin
                red_next   = ch_b;
                green_next = ch_a;
                blue_next  = ch_z;
            end
            RGN_BG:
            begin
                red_next   = ch_z;
                green_next = ch_b;
                blue_next  = ch_a;
            end
            default:
            begin
                red_next   = ch_z;
                green_next = ch_z;
                blue_next  = ch_z;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    a_latency_hit: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("request did not complete after pipeline latency");

    a_latency_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LAT !done)
        else $error("result reported with no matching request");

    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (start && saturation == '0) |-> ##LAT (red == green && green == blue))
        else $error("zero saturation did not give equal channels");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (red <= ONE_Q && green <= ONE_Q && blue <= ONE_Q))
        else $error("channel above full scale");

endmodule
